>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> design/mta_pkg.sv
// ----------------------------------------------------------------------------
// mta_pkg
// Types, codes and constants of the mesh tangent accumulator.
// ----------------------------------------------------------------------------
package mta_pkg;

    localparam int DEF_VERTEX_DEPTH  = 1024;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int INDEX_W = 10;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 8;
    localparam int PROD_W  = 64;
    localparam int ACC_W   = 65;
    localparam int MAG_W   = 64;
    localparam int QUOT_W  = 33;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ABORT   = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef struct packed {
        logic [1:0]                opcode;
        logic [INDEX_W-1:0]        index_a;
        logic [INDEX_W-1:0]        index_b;
        logic [INDEX_W-1:0]        index_c;
        logic signed [DATA_W-1:0]  pos_x;
        logic signed [DATA_W-1:0]  pos_y;
        logic signed [DATA_W-1:0]  pos_z;
        logic signed [DATA_W-1:0]  tex_u;
        logic signed [DATA_W-1:0]  tex_v;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0]  tangent_x;
        logic signed [DATA_W-1:0]  tangent_y;
        logic signed [DATA_W-1:0]  tangent_z;
        logic [COUNT_W-1:0]        contribution_count;
        logic [1:0]                status;
    } t_result;

    typedef struct packed {
        logic signed [DATA_W-1:0]  x;
        logic signed [DATA_W-1:0]  y;
        logic signed [DATA_W-1:0]  z;
        logic signed [DATA_W-1:0]  u;
        logic signed [DATA_W-1:0]  v;
    } t_vtx;

    typedef struct packed {
        logic signed [DATA_W-1:0]  x;
        logic signed [DATA_W-1:0]  y;
        logic signed [DATA_W-1:0]  z;
    } t_tan;

    typedef enum logic [4:0] {
        S_IDLE, S_CLEAR, S_DECODE, S_R_RD, S_R_CAP,
        S_T_RDA, S_T_RDB, S_T_RDC, S_T_CAPC,
        S_D_M1, S_D_M2, S_D_SUB, S_D_CHK,
        S_N_M1, S_N_M2, S_N_SUB, S_N_DIV, S_N_RUN, S_N_WR,
        S_F_RD, S_F_CAP, S_F_CHK,
        S_A_M, S_A_SUM, S_A_DIV, S_A_RUN, S_A_WR,
        S_F_WR, S_DONE
    } t_state;

    typedef enum logic [1:0] {ADDR_A, ADDR_B, ADDR_C, ADDR_CLR} t_addr_sel;

    typedef enum logic [2:0] {MUL_DET1, MUL_DET2, MUL_NUM1, MUL_NUM2, MUL_AVG} t_mul_sel;

    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_SUB, ACC_SUM} t_acc_op;

    typedef struct packed {
        logic       item_latch;
        t_addr_sel  addr_sel;
        logic       vtx_rd;
        logic       vtx_wr;
        logic       tan_rd;
        logic       tan_wr;
        logic       cnt_wr;
        logic       cnt_inc;
        logic       clr_step;
        logic       cap_a;
        logic       cap_b;
        logic       cap_c;
        logic       mul_en;
        t_mul_sel   mul_sel;
        t_acc_op    acc_op;
        logic       det_save;
        logic       div_start;
        logic       div_avg;
        logic       tan_save;
        logic       old_cap;
        logic       new_copy;
        logic       new_save;
        logic [1:0] k;
        logic       res_load;
        logic       res_read;
        logic [1:0] res_status;
    } t_ctl;

    typedef struct packed {
        logic [1:0] opcode;
        logic       a_ok;
        logic       all_ok;
        logic       det_zero;
        logic       div_busy;
        logic       n_zero;
        logic       clr_last;
    } t_sts;

endpackage

>>> design/mta_ram.sv
// ----------------------------------------------------------------------------
// mta_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module mta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/mta_div.sv
// ----------------------------------------------------------------------------
// mta_div
// Radix-2 restoring divider producing a saturated signed fixed-point quotient.
// ----------------------------------------------------------------------------
module mta_div #(
    parameter int FRACTION_BITS = mta_pkg::DEF_FRACTION_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_scale,
    input  logic                              i_neg,
    input  logic [mta_pkg::MAG_W-1:0]         i_num,
    input  logic [mta_pkg::MAG_W-1:0]         i_den,
    output logic                              o_busy,
    output logic signed [mta_pkg::DATA_W-1:0] o_value
);

    import mta_pkg::*;

    localparam int NW    = MAG_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(QUOT_W + 1);
    localparam logic [QUOT_W-1:0] LIM_POS =
        {{(QUOT_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic [QUOT_W-1:0] LIM_NEG = LIM_POS + QUOT_W'(1);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [MAG_W-1:0]    r_rem;
    logic [QUOT_W-1:0]   r_dn;
    logic [MAG_W-1:0]    r_den;
    logic [QUOT_W-1:0]   r_q;
    logic                r_ovf;
    logic                r_neg;

    logic [NW-1:0]       w_full;
    logic [MAG_W-1:0]    w_top;
    logic [MAG_W:0]      w_trial;
    logic [MAG_W:0]      w_diff;
    logic [QUOT_W-1:0]   w_lim;
    logic [QUOT_W-1:0]   w_mag;
    logic [QUOT_W-1:0]   w_sgn;

    assign w_full  = i_scale ? {i_num, {FRACTION_BITS{1'b0}}}
                             : {{FRACTION_BITS{1'b0}}, i_num};
    assign w_top   = MAG_W'(w_full[NW-1:QUOT_W]);
    assign w_trial = {r_rem, r_dn[QUOT_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QUOT_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= w_top;
            r_dn  <= w_full[QUOT_W-1:0];
            r_den <= i_den;
            r_q   <= '0;
            r_ovf <= (w_top >= i_den);
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_dn <= r_dn << 1;
            if (!w_diff[MAG_W]) begin
                r_rem <= w_diff[MAG_W-1:0];
                r_q   <= {r_q[QUOT_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[MAG_W-1:0];
                r_q   <= {r_q[QUOT_W-2:0], 1'b0};
            end
        end
    end

    assign w_lim   = r_neg ? LIM_NEG : LIM_POS;
    assign w_mag   = (r_ovf || (r_q > w_lim)) ? w_lim : r_q;
    assign w_sgn   = r_neg ? ('0 - w_mag) : w_mag;
    assign o_value = w_sgn[DATA_W-1:0];
    assign o_busy  = r_busy;

endmodule

>>> design/mta_dp.sv
// ----------------------------------------------------------------------------
// mta_dp
// Datapath: vertex, tangent and count memories, multiplier, accumulator,
// divider and result register.
// ----------------------------------------------------------------------------
module mta_dp #(
    parameter int VERTEX_DEPTH  = mta_pkg::DEF_VERTEX_DEPTH,
    parameter int FRACTION_BITS = mta_pkg::DEF_FRACTION_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mta_pkg::t_item   i_item,
    input  mta_pkg::t_ctl    i_ctl,
    output mta_pkg::t_sts    o_sts,
    output mta_pkg::t_result o_result
);

    import mta_pkg::*;

    localparam int AW = $clog2(VERTEX_DEPTH);
    localparam logic [31:0] DEPTH_U = 32'(VERTEX_DEPTH);

    function automatic logic signed [DATA_W-1:0] sat_diff(
        input logic signed [DATA_W-1:0] hi,
        input logic signed [DATA_W-1:0] lo
    );
        logic signed [DATA_W:0] d;
        d = {hi[DATA_W-1], hi} - {lo[DATA_W-1], lo};
        if (d[DATA_W] != d[DATA_W-1]) begin
            return d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return d[DATA_W-1:0];
    endfunction

    t_item                    r_item;
    logic [AW-1:0]            r_clr_addr;
    t_vtx                     r_va;
    logic signed [DATA_W-1:0] r_e1 [3];
    logic signed [DATA_W-1:0] r_e2 [3];
    logic signed [DATA_W-1:0] r_du1, r_dv1, r_du2, r_dv2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [MAG_W-1:0]         r_dmag;
    logic                     r_dneg;
    logic signed [DATA_W-1:0] r_tan [3];
    logic signed [DATA_W-1:0] r_old [3];
    logic signed [DATA_W-1:0] r_new [3];
    logic [COUNT_W-1:0]       r_n;
    t_result                  r_res;

    logic [INDEX_W-1:0]       w_idx;
    logic [AW+INDEX_W-1:0]    w_idx_ext;
    logic [AW-1:0]            w_addr;
    t_vtx                     w_vtx_wdata;
    t_vtx                     w_vtx_rdata;
    t_tan                     w_tan_wdata;
    t_tan                     w_tan_rdata;
    logic [COUNT_W-1:0]       w_cnt_wdata;
    logic [COUNT_W-1:0]       w_cnt_rdata;
    logic signed [DATA_W-1:0] w_ma, w_mb;
    logic [ACC_W-1:0]         w_acc_abs;
    logic                     w_acc_neg;
    logic [MAG_W-1:0]         w_acc_mag;
    logic [MAG_W-1:0]         w_den;
    logic                     w_div_neg;
    logic                     w_div_busy;
    logic signed [DATA_W-1:0] w_div_value;

    always_comb begin
        case (i_ctl.addr_sel)
            ADDR_A:  w_idx = r_item.index_a;
            ADDR_B:  w_idx = r_item.index_b;
            ADDR_C:  w_idx = r_item.index_c;
            default: w_idx = r_item.index_a;
        endcase
    end

    assign w_idx_ext = {{AW{1'b0}}, w_idx};
    assign w_addr    = (i_ctl.addr_sel == ADDR_CLR) ? r_clr_addr : w_idx_ext[AW-1:0];

    assign w_vtx_wdata = '{x: r_item.pos_x, y: r_item.pos_y, z: r_item.pos_z,
                           u: r_item.tex_u, v: r_item.tex_v};
    assign w_tan_wdata = '{x: r_new[0], y: r_new[1], z: r_new[2]};
    assign w_cnt_wdata = !i_ctl.cnt_inc ? '0 :
                         (r_n == COUNT_MAX) ? r_n : r_n + COUNT_W'(1);

    mta_ram #(.WIDTH($bits(t_vtx)), .DEPTH(VERTEX_DEPTH)) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.vtx_wr),
        .i_waddr (w_addr),
        .i_wdata (w_vtx_wdata),
        .i_re    (i_ctl.vtx_rd),
        .i_raddr (w_addr),
        .o_rdata (w_vtx_rdata)
    );

    mta_ram #(.WIDTH($bits(t_tan)), .DEPTH(VERTEX_DEPTH)) u_tan_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.tan_wr),
        .i_waddr (w_addr),
        .i_wdata (w_tan_wdata),
        .i_re    (i_ctl.tan_rd),
        .i_raddr (w_addr),
        .o_rdata (w_tan_rdata)
    );

    mta_ram #(.WIDTH(COUNT_W), .DEPTH(VERTEX_DEPTH)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.cnt_wr),
        .i_waddr (w_addr),
        .i_wdata (w_cnt_wdata),
        .i_re    (i_ctl.tan_rd),
        .i_raddr (w_addr),
        .o_rdata (w_cnt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_ctl.clr_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.item_latch) begin
            r_item <= i_item;
        end
        if (i_ctl.cap_a) begin
            r_va <= w_vtx_rdata;
        end
        if (i_ctl.cap_b) begin
            r_e1[0] <= sat_diff(w_vtx_rdata.x, r_va.x);
            r_e1[1] <= sat_diff(w_vtx_rdata.y, r_va.y);
            r_e1[2] <= sat_diff(w_vtx_rdata.z, r_va.z);
            r_du1   <= sat_diff(w_vtx_rdata.u, r_va.u);
            r_dv1   <= sat_diff(w_vtx_rdata.v, r_va.v);
        end
        if (i_ctl.cap_c) begin
            r_e2[0] <= sat_diff(w_vtx_rdata.x, r_va.x);
            r_e2[1] <= sat_diff(w_vtx_rdata.y, r_va.y);
            r_e2[2] <= sat_diff(w_vtx_rdata.z, r_va.z);
            r_du2   <= sat_diff(w_vtx_rdata.u, r_va.u);
            r_dv2   <= sat_diff(w_vtx_rdata.v, r_va.v);
        end
    end

    always_comb begin
        case (i_ctl.mul_sel)
            MUL_DET1: begin
                w_ma = r_du1;
                w_mb = r_dv2;
            end
            MUL_DET2: begin
                w_ma = r_du2;
                w_mb = r_dv1;
            end
            MUL_NUM1: begin
                w_ma = r_dv2;
                w_mb = r_e1[i_ctl.k];
            end
            MUL_NUM2: begin
                w_ma = r_dv1;
                w_mb = r_e2[i_ctl.k];
            end
            MUL_AVG: begin
                w_ma = r_old[i_ctl.k];
                w_mb = {{(DATA_W-COUNT_W){1'b0}}, r_n};
            end
            default: begin
                w_ma = r_du1;
                w_mb = r_dv2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_ma * w_mb;
        end
        case (i_ctl.acc_op)
            ACC_LOAD: r_acc <= {r_prod[PROD_W-1], r_prod};
            ACC_SUB:  r_acc <= r_acc - {r_prod[PROD_W-1], r_prod};
            ACC_SUM:  r_acc <= {r_prod[PROD_W-1], r_prod}
                             + {{(ACC_W-DATA_W){r_tan[i_ctl.k][DATA_W-1]}}, r_tan[i_ctl.k]};
            default:  r_acc <= r_acc;
        endcase
    end

    assign w_acc_neg = r_acc[ACC_W-1];
    assign w_acc_abs = w_acc_neg ? ('0 - r_acc) : r_acc;
    assign w_acc_mag = w_acc_abs[MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.det_save) begin
            r_dmag <= w_acc_mag;
            r_dneg <= w_acc_neg;
        end
    end

    assign w_den     = i_ctl.div_avg ? MAG_W'(r_n) + MAG_W'(1) : r_dmag;
    assign w_div_neg = i_ctl.div_avg ? w_acc_neg : (w_acc_neg ^ r_dneg);

    mta_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_scale (!i_ctl.div_avg),
        .i_neg   (w_div_neg),
        .i_num   (w_acc_mag),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_value (w_div_value)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.tan_save) begin
            r_tan[i_ctl.k] <= w_div_value;
        end
        if (i_ctl.old_cap) begin
            r_old[0] <= w_tan_rdata.x;
            r_old[1] <= w_tan_rdata.y;
            r_old[2] <= w_tan_rdata.z;
            r_n      <= w_cnt_rdata;
        end
        if (i_ctl.new_copy) begin
            r_new[0] <= r_tan[0];
            r_new[1] <= r_tan[1];
            r_new[2] <= r_tan[2];
        end else if (i_ctl.new_save) begin
            r_new[i_ctl.k] <= w_div_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.res_load) begin
            if (i_ctl.res_read) begin
                r_res.tangent_x          <= w_tan_rdata.x;
                r_res.tangent_y          <= w_tan_rdata.y;
                r_res.tangent_z          <= w_tan_rdata.z;
                r_res.contribution_count <= w_cnt_rdata;
            end else begin
                r_res.tangent_x          <= '0;
                r_res.tangent_y          <= '0;
                r_res.tangent_z          <= '0;
                r_res.contribution_count <= '0;
            end
            r_res.status <= i_ctl.res_status;
        end
    end

    assign o_sts.opcode   = r_item.opcode;
    assign o_sts.a_ok     = (32'(r_item.index_a) < DEPTH_U);
    assign o_sts.all_ok   = (32'(r_item.index_a) < DEPTH_U) && (32'(r_item.index_b) < DEPTH_U)
                            && (32'(r_item.index_c) < DEPTH_U);
    assign o_sts.det_zero = (r_acc == '0);
    assign o_sts.div_busy = w_div_busy;
    assign o_sts.n_zero   = (r_n == '0);
    assign o_sts.clr_last = (r_clr_addr == AW'(VERTEX_DEPTH - 1));
    assign o_result       = r_res;

endmodule

>>> design/mta_ctrl.sv
// ----------------------------------------------------------------------------
// mta_ctrl
// Controller: sequences loads, reads and triangle processing in the datapath.
// ----------------------------------------------------------------------------
module mta_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  mta_pkg::t_sts i_sts,
    output mta_pkg::t_ctl o_ctl,
    output logic          busy,
    output logic          o_done
);

    import mta_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;
    logic [1:0] r_corner, n_corner;
    logic       r_abort, n_abort;
    t_addr_sel  w_corner_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_k      <= '0;
            r_corner <= '0;
            r_abort  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_corner <= n_corner;
            r_abort  <= n_abort;
        end
    end

    always_comb begin
        case (r_corner)
            2'd0:    w_corner_sel = ADDR_A;
            2'd1:    w_corner_sel = ADDR_B;
            default: w_corner_sel = ADDR_C;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_corner = r_corner;
        n_abort  = r_abort;
        case (r_state)
            S_IDLE:   if (start) n_state = S_DECODE;
            S_CLEAR:  if (i_sts.clr_last) n_state = S_IDLE;
            S_DECODE: begin
                case (i_sts.opcode)
                    OP_LOAD: begin
                        if (i_sts.a_ok) n_abort = 1'b0;
                        n_state = S_DONE;
                    end
                    OP_TRI: begin
                        n_state = (r_abort || !i_sts.all_ok) ? S_DONE : S_T_RDA;
                    end
                    OP_READ: n_state = i_sts.a_ok ? S_R_RD : S_DONE;
                    default: n_state = S_DONE;
                endcase
            end
            S_R_RD:   n_state = S_R_CAP;
            S_R_CAP:  n_state = S_DONE;
            S_T_RDA:  n_state = S_T_RDB;
            S_T_RDB:  n_state = S_T_RDC;
            S_T_RDC:  n_state = S_T_CAPC;
            S_T_CAPC: n_state = S_D_M1;
            S_D_M1:   n_state = S_D_M2;
            S_D_M2:   n_state = S_D_SUB;
            S_D_SUB:  n_state = S_D_CHK;
            S_D_CHK: begin
                n_k = '0;
                if (i_sts.det_zero) begin
                    n_abort = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_N_M1;
                end
            end
            S_N_M1:   n_state = S_N_M2;
            S_N_M2:   n_state = S_N_SUB;
            S_N_SUB:  n_state = S_N_DIV;
            S_N_DIV:  n_state = S_N_RUN;
            S_N_RUN:  if (!i_sts.div_busy) n_state = S_N_WR;
            S_N_WR: begin
                if (r_k == 2'd2) begin
                    n_corner = '0;
                    n_state  = S_F_RD;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_N_M1;
                end
            end
            S_F_RD:   n_state = S_F_CAP;
            S_F_CAP:  n_state = S_F_CHK;
            S_F_CHK: begin
                n_k     = '0;
                n_state = i_sts.n_zero ? S_F_WR : S_A_M;
            end
            S_A_M:    n_state = S_A_SUM;
            S_A_SUM:  n_state = S_A_DIV;
            S_A_DIV:  n_state = S_A_RUN;
            S_A_RUN:  if (!i_sts.div_busy) n_state = S_A_WR;
            S_A_WR: begin
                if (r_k == 2'd2) begin
                    n_state = S_F_WR;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_A_M;
                end
            end
            S_F_WR: begin
                if (r_corner == 2'd2) begin
                    n_state = S_DONE;
                end else begin
                    n_corner = r_corner + 2'd1;
                    n_state  = S_F_RD;
                end
            end
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl          = '0;
        o_ctl.k        = r_k;
        o_ctl.addr_sel = ADDR_A;
        busy           = (r_state != S_IDLE);
        o_done         = (r_state == S_DONE);
        case (r_state)
            S_IDLE:   o_ctl.item_latch = start;
            S_CLEAR: begin
                o_ctl.addr_sel = ADDR_CLR;
                o_ctl.cnt_wr   = 1'b1;
                o_ctl.clr_step = 1'b1;
            end
            S_DECODE: begin
                case (i_sts.opcode)
                    OP_LOAD: begin
                        o_ctl.vtx_wr   = i_sts.a_ok;
                        o_ctl.cnt_wr   = i_sts.a_ok;
                        o_ctl.res_load = 1'b1;
                    end
                    OP_TRI: begin
                        if (r_abort || !i_sts.all_ok) begin
                            o_ctl.res_load   = 1'b1;
                            o_ctl.res_status = ST_IGNORED;
                        end
                    end
                    OP_READ:  o_ctl.res_load = !i_sts.a_ok;
                    default:  o_ctl.res_load = 1'b1;
                endcase
            end
            S_R_RD:   o_ctl.tan_rd = 1'b1;
            S_R_CAP: begin
                o_ctl.res_load = 1'b1;
                o_ctl.res_read = 1'b1;
            end
            S_T_RDA:  o_ctl.vtx_rd = 1'b1;
            S_T_RDB: begin
                o_ctl.addr_sel = ADDR_B;
                o_ctl.vtx_rd   = 1'b1;
                o_ctl.cap_a    = 1'b1;
            end
            S_T_RDC: begin
                o_ctl.addr_sel = ADDR_C;
                o_ctl.vtx_rd   = 1'b1;
                o_ctl.cap_b    = 1'b1;
            end
            S_T_CAPC: o_ctl.cap_c = 1'b1;
            S_D_M1: begin
                o_ctl.mul_en  = 1'b1;
                o_ctl.mul_sel = MUL_DET1;
            end
            S_D_M2: begin
                o_ctl.mul_en  = 1'b1;
                o_ctl.mul_sel = MUL_DET2;
                o_ctl.acc_op  = ACC_LOAD;
            end
            S_D_SUB:  o_ctl.acc_op = ACC_SUB;
            S_D_CHK: begin
                o_ctl.det_save = 1'b1;
                if (i_sts.det_zero) begin
                    o_ctl.res_load   = 1'b1;
                    o_ctl.res_status = ST_ABORT;
                end
            end
            S_N_M1: begin
                o_ctl.mul_en  = 1'b1;
                o_ctl.mul_sel = MUL_NUM1;
            end
            S_N_M2: begin
                o_ctl.mul_en  = 1'b1;
                o_ctl.mul_sel = MUL_NUM2;
                o_ctl.acc_op  = ACC_LOAD;
            end
            S_N_SUB:  o_ctl.acc_op = ACC_SUB;
            S_N_DIV:  o_ctl.div_start = 1'b1;
            S_N_WR:   o_ctl.tan_save = 1'b1;
            S_F_RD: begin
                o_ctl.addr_sel = w_corner_sel;
                o_ctl.tan_rd   = 1'b1;
            end
            S_F_CAP:  o_ctl.old_cap = 1'b1;
            S_F_CHK:  o_ctl.new_copy = i_sts.n_zero;
            S_A_M: begin
                o_ctl.mul_en  = 1'b1;
                o_ctl.mul_sel = MUL_AVG;
            end
            S_A_SUM:  o_ctl.acc_op = ACC_SUM;
            S_A_DIV: begin
                o_ctl.div_start = 1'b1;
                o_ctl.div_avg   = 1'b1;
            end
            S_A_WR:   o_ctl.new_save = 1'b1;
            S_F_WR: begin
                o_ctl.addr_sel = w_corner_sel;
                o_ctl.tan_wr   = 1'b1;
                o_ctl.cnt_wr   = 1'b1;
                o_ctl.cnt_inc  = 1'b1;
                o_ctl.res_load = (r_corner == 2'd2);
            end
            default: begin
            end
        endcase
    end

endmodule

>>> design/mesh_tangent_accumulator.sv
// ----------------------------------------------------------------------------
// mesh_tangent_accumulator
// Per-vertex tangent averaging over a loaded vertex table, Q16.16 arithmetic.
// ----------------------------------------------------------------------------
// A request on i_item is taken at a rising edge with start high and busy low.
// Exactly one result per request appears on o_result for one cycle, marked by
// o_done; the receiver cannot stall it, and busy stays high until it is shown.
// A load registers its result in the decode state, a read after a RAM read.
// A triangle runs three tangent divisions, and up to nine averaging divisions
// (none when all three corner counts are zero), one after another on a single
// radix-2 divider of 33 steps each, with one multiplier shared by every product.
// An ignored triangle ends at decode, an aborted one at the determinant check.
// After reset the block sweeps the count memory to zero, one entry per cycle,
// over all VERTEX_DEPTH entries with busy high; no request is taken meanwhile.
// The vertex and tangent memories are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mesh_tangent_accumulator #(
    parameter int VERTEX_DEPTH  = mta_pkg::DEF_VERTEX_DEPTH,
    parameter int FRACTION_BITS = mta_pkg::DEF_FRACTION_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  mta_pkg::t_item   i_item,
    output logic             busy,
    output logic             o_done,
    output mta_pkg::t_result o_result
);

    import mta_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    mta_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .busy    (busy),
        .o_done  (o_done)
    );

    mta_dp #(
        .VERTEX_DEPTH  (VERTEX_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctl    (w_ctl),
        .o_sts    (w_sts),
        .o_result (o_result)
    );

    `ASSERT_IMPLIES(a_done_busy, i_clk, i_rst_n, o_done, busy, "result strobe while idle")
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "request not held busy")
    `ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result strobe too long")

endmodule

>>> test/mta_tangent_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mta_tangent_check
// Watches the request and result channels of the mesh tangent accumulator,
// predicts each result from its own copy of the vertex and tangent tables,
// and compares every result, all fields at once, in request order.
// ----------------------------------------------------------------------------
module mta_tangent_check
    import mta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_item       i_item,
    input  logic        i_done,
    input  t_result     i_result,
    output int          o_fail_count,
    output int          o_waiting,
    output logic [1023:0] o_tangent_set
);

    localparam int FB = DEF_FRACTION_BITS;

    t_vtx              vtx_mem [DEF_VERTEX_DEPTH];
    t_tan              tan_mem [DEF_VERTEX_DEPTH];
    logic [COUNT_W-1:0] cnt_mem [DEF_VERTEX_DEPTH];
    logic              aborted;
    t_result           pending_results [$];

    function automatic logic signed [31:0] sat_diff(logic signed [31:0] p, logic signed [31:0] q);
        logic signed [32:0] d;
        d = {p[31], p} - {q[31], q};
        if (d > 33'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (d < -33'sh0_8000_0000) return 32'sh8000_0000;
        return d[31:0];
    endfunction

    function automatic logic signed [31:0] fix_quotient(logic signed [65:0] num,
                                                        logic signed [65:0] den);
        logic        neg;
        logic [97:0] un;
        logic [97:0] ud;
        logic [97:0] q;
        logic [97:0] lim;
        neg = num[65] ^ den[65];
        un  = num[65] ? 98'(-num) : 98'(num);
        ud  = den[65] ? 98'(-den) : 98'(den);
        q   = (un << FB) / ud;
        lim = neg ? 98'h8000_0000 : 98'h7FFF_FFFF;
        if (q > lim) q = lim;
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic logic signed [31:0] running_mean(logic signed [31:0] old_v,
                                                        logic signed [31:0] add_v, int n);
        longint sum;
        if (n == 0) return add_v;
        sum = longint'(old_v) * n + longint'(add_v);
        return 32'(sum / (n + 1));
    endfunction

    function automatic logic [1:0] run_triangle(int a, int b, int c);
        logic signed [31:0] e1x, e1y, e1z, e2x, e2y, e2z, du1, dv1, du2, dv2;
        logic signed [65:0] det;
        t_tan               t;
        int                 corner [3];
        int                 v;
        int                 n;
        if (aborted) return ST_IGNORED;
        e1x = sat_diff(vtx_mem[b].x, vtx_mem[a].x);
        e1y = sat_diff(vtx_mem[b].y, vtx_mem[a].y);
        e1z = sat_diff(vtx_mem[b].z, vtx_mem[a].z);
        e2x = sat_diff(vtx_mem[c].x, vtx_mem[a].x);
        e2y = sat_diff(vtx_mem[c].y, vtx_mem[a].y);
        e2z = sat_diff(vtx_mem[c].z, vtx_mem[a].z);
        du1 = sat_diff(vtx_mem[b].u, vtx_mem[a].u);
        dv1 = sat_diff(vtx_mem[b].v, vtx_mem[a].v);
        du2 = sat_diff(vtx_mem[c].u, vtx_mem[a].u);
        dv2 = sat_diff(vtx_mem[c].v, vtx_mem[a].v);
        det = 66'(du1) * 66'(dv2) - 66'(du2) * 66'(dv1);
        if (det == 0) begin
            aborted = 1'b1;
            return ST_ABORT;
        end
        t.x = fix_quotient(66'(dv2) * 66'(e1x) - 66'(dv1) * 66'(e2x), det);
        t.y = fix_quotient(66'(dv2) * 66'(e1y) - 66'(dv1) * 66'(e2y), det);
        t.z = fix_quotient(66'(dv2) * 66'(e1z) - 66'(dv1) * 66'(e2z), det);
        corner[0] = a;
        corner[1] = b;
        corner[2] = c;
        for (int k = 0; k < 3; k++) begin
            v = corner[k];
            n = cnt_mem[v];
            tan_mem[v].x = running_mean(tan_mem[v].x, t.x, n);
            tan_mem[v].y = running_mean(tan_mem[v].y, t.y, n);
            tan_mem[v].z = running_mean(tan_mem[v].z, t.z, n);
            if (n < COUNT_MAX) cnt_mem[v] = COUNT_W'(n + 1);
        end
        return ST_OK;
    endfunction

    function automatic t_result predict_request(t_item it);
        t_result r;
        r = '0;
        case (it.opcode)
            OP_LOAD: begin
                vtx_mem[it.index_a] = '{x: it.pos_x, y: it.pos_y, z: it.pos_z,
                                        u: it.tex_u, v: it.tex_v};
                cnt_mem[it.index_a] = '0;
                aborted = 1'b0;
            end
            OP_TRI: r.status = run_triangle(it.index_a, it.index_b, it.index_c);
            OP_READ: begin
                r.tangent_x          = tan_mem[it.index_a].x;
                r.tangent_y          = tan_mem[it.index_a].y;
                r.tangent_z          = tan_mem[it.index_a].z;
                r.contribution_count = cnt_mem[it.index_a];
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result       exp_r;
        logic [1023:0] touched;
        if (!i_rst_n) begin
            foreach (cnt_mem[i]) cnt_mem[i] = '0;
            aborted = 1'b0;
            pending_results.delete();
            o_fail_count  <= 0;
            o_waiting     <= 0;
            o_tangent_set <= '0;
        end else begin
            touched = '0;
            if (i_done) begin
                if (pending_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result with no request pending: %h", $realtime, i_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (exp_r !== i_result) begin
                        if (o_fail_count < 10)
                            $display("%0t: mismatch exp tx=%h ty=%h tz=%h cnt=%0d st=%0d act tx=%h ty=%h tz=%h cnt=%0d st=%0d",
                                     $realtime, exp_r.tangent_x, exp_r.tangent_y,
                                     exp_r.tangent_z, exp_r.contribution_count, exp_r.status,
                                     i_result.tangent_x, i_result.tangent_y,
                                     i_result.tangent_z, i_result.contribution_count,
                                     i_result.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                exp_r = predict_request(i_item);
                pending_results.push_back(exp_r);
                if (i_item.opcode == OP_TRI && exp_r.status == ST_OK) begin
                    touched[i_item.index_a] = 1'b1;
                    touched[i_item.index_b] = 1'b1;
                    touched[i_item.index_c] = 1'b1;
                end
            end
            o_tangent_set <= o_tangent_set | touched;
            o_waiting     <= pending_results.size();
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives load, triangle and read requests into the mesh tangent accumulator
// under varying sender gaps, starting with hand-picked corner cases and then
// random vertex sets, and reports the verdict of the tangent checker.
// ----------------------------------------------------------------------------
module tb_top;
    import mta_pkg::*;

    localparam int ITEM_TARGET = 1400;
    localparam int STALL_LIMIT = 8000;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    t_item         i_item  = '0;
    logic          busy;
    logic          o_done;
    t_result       o_result;
    int            fail_count;
    int            waiting;
    logic [1023:0] tangent_set;

    bit            is_loaded [1024];
    int            loaded_q [$];
    int            gap_pct;
    int            issued;
    int            quiet_cycles;

    mesh_tangent_accumulator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    mta_tangent_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_tangent_set(tangent_set)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic issue(t_item it);
        int gap;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        if (it.opcode == OP_LOAD && !is_loaded[it.index_a]) begin
            is_loaded[it.index_a] = 1'b1;
            loaded_q.push_back(int'(it.index_a));
        end
        issued++;
    endtask

    function automatic t_item noise_item(logic [1:0] op);
        t_item it;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it.opcode = op;
        return it;
    endfunction

    function automatic t_item load_item(int idx, logic signed [31:0] x, logic signed [31:0] y,
                                        logic signed [31:0] z, logic signed [31:0] u,
                                        logic signed [31:0] v);
        t_item it;
        it = noise_item(OP_LOAD);
        it.index_a = INDEX_W'(idx);
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.tex_u = u;
        it.tex_v = v;
        return it;
    endfunction

    function automatic t_item tri_item(int a, int b, int c);
        t_item it;
        it = noise_item(OP_TRI);
        it.index_a = INDEX_W'(a);
        it.index_b = INDEX_W'(b);
        it.index_c = INDEX_W'(c);
        return it;
    endfunction

    function automatic t_item read_item(int idx);
        t_item it;
        it = noise_item(OP_READ);
        it.index_a = INDEX_W'(idx);
        return it;
    endfunction

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $urandom;
            default: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh1_FFFF;
        endcase
    endfunction

    function automatic int rand_index();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
    endfunction

    function automatic t_item rand_load(int idx);
        return load_item(idx, rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
    endfunction

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
    endtask

    task automatic random_step();
        int    a, b, c, pick;
        t_item it;
        pick = $urandom_range(0, 99);
        if (pick < 45 || loaded_q.size() < 3) begin
            a = rand_index();
            do b = rand_index(); while (b == a);
            do c = rand_index(); while (c == a || c == b);
            issue(rand_load(a));
            issue(rand_load(b));
            it = rand_load(c);
            if ($urandom_range(0, 9) == 0) begin
                it.tex_u = 32'sh0001_0000;
                it.tex_v = 32'sh0001_0000;
            end
            issue(it);
            issue(tri_item(a, b, c));
            if ($urandom_range(0, 1)) issue(tri_item(c, a, b));
        end else if (pick < 65) begin
            issue(tri_item(loaded_q[$urandom_range(0, loaded_q.size() - 1)],
                           loaded_q[$urandom_range(0, loaded_q.size() - 1)],
                           loaded_q[$urandom_range(0, loaded_q.size() - 1)]));
        end else if (pick < 87) begin
            a = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
            if (tangent_set[a]) issue(read_item(a));
        end else if (pick < 93) begin
            issue(noise_item(2'd3));
        end else begin
            issue(rand_load(rand_index()));
        end
    endtask

    initial begin
        int phase_pct [4];
        phase_pct = '{0, 46, 0, 9};
        gap_pct = 0;
        issued = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(load_item(0, 0, 0, 0, 0, 0));
        issue(load_item(1, 32'sh1_0000, 0, 0, 32'sh1_0000, 0));
        issue(load_item(2, 0, 32'sh1_0000, 0, 0, 32'sh1_0000));
        issue(tri_item(0, 1, 2));
        issue(read_item(0));
        issue(read_item(1));
        issue(tri_item(2, 0, 1));
        issue(read_item(2));
        issue(tri_item(0, 0, 1));
        issue(tri_item(0, 1, 2));
        issue(noise_item(2'd3));
        issue(read_item(0));
        issue(load_item(1023, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                        32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        issue(load_item(3, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                        32'sh8000_0000, 32'sh8000_0000));
        issue(load_item(4, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1));
        issue(tri_item(3, 1023, 4));
        issue(read_item(1023));
        issue(read_item(3));
        issue(load_item(5, 32'sh7000_0000, 32'sh8000_0000, 0, 0, 0));
        issue(load_item(6, 32'sh8000_0000, 32'sh7000_0000, 1, 1, 0));
        issue(load_item(7, 0, 1, 32'sh7FFF_0000, 0, 1));
        issue(tri_item(5, 6, 7));
        issue(read_item(5));
        issue(read_item(7));

        while (issued < ITEM_TARGET) begin
            gap_pct = phase_pct[(issued / 60) % 4];
            random_step();
            if (issued >= ITEM_TARGET / 2 && !is_loaded[100]) begin
                wait_drained();
                issue(load_item(100, 0, 0, 0, 0, 0));
                issue(load_item(101, 32'sh3_0000, 32'sh1_0000, 0, 32'sh2_0000, 0));
                issue(load_item(102, 0, 32'sh2_0000, 32'sh1_0000, 0, 32'sh2_0000));
                repeat (258) issue(tri_item(100, 101, 102));
                issue(read_item(100));
                issue(read_item(102));
            end
        end

        wait_drained();
        repeat (600) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
